/* rtl/ppil_pkg.sv */
// ----------------------------------------------------------------------------
// ppil_pkg
// Types, codes and small helpers used by the plane pair intersection line
// block.
// ----------------------------------------------------------------------------
package ppil_pkg;

  localparam int unsigned WordBits = 32;

  typedef enum logic [1:0] {
    StLine     = 2'd0,
    StReject   = 2'd1,
    StParallel = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    AxisX = 2'd0,
    AxisY = 2'd1,
    AxisZ = 2'd2
  } axis_e;

  typedef logic signed [WordBits-1:0] word_t;

  typedef struct packed {
    word_t p1_a;
    word_t p1_b;
    word_t p1_c;
    word_t p1_d;
    word_t p2_a;
    word_t p2_b;
    word_t p2_c;
    word_t p2_d;
    logic  normalize;
  } in_item_t;

  typedef struct packed {
    status_e status;
    axis_e   param_axis;
    word_t   slope_first;
    word_t   offset_first;
    word_t   slope_second;
    word_t   offset_second;
    word_t   dir_x;
    word_t   dir_y;
    word_t   dir_z;
  } res_item_t;

  // control that rides along with an item through the pipeline
  typedef struct packed {
    status_e status;
    axis_e   axis;
    logic    norm;
  } ctl_t;

  // line data carried through the normalize section
  typedef struct packed {
    ctl_t                            ctl;
    logic [3:0][WordBits-1:0]        lin;  // slope1, offset1, slope2, offset2
    logic [2:0][WordBits-1:0]        dir;  // x, y, z
    logic [2:0][WordBits-1:0]        mag;  // magnitudes of dir
  } line_t;

  function automatic logic [WordBits-1:0] mag_w(logic [WordBits-1:0] v);
    return v[WordBits-1] ? (~v + WordBits'(1)) : v;
  endfunction

  // clamp a rounded quotient magnitude to the word range and apply the sign
  function automatic logic [WordBits-1:0] sat_round(logic [WordBits-1:0] quo, logic ovf,
                                                    logic neg);
    logic [WordBits-1:0] lim;
    logic [WordBits-1:0] mag;
    lim = neg ? {1'b1, {(WordBits-1){1'b0}}} : {1'b0, {(WordBits-1){1'b1}}};
    mag = (ovf || (quo > lim)) ? lim : quo;
    return neg ? (~mag + WordBits'(1)) : mag;
  endfunction

endpackage

/* rtl/ppil_div.sv */
// ----------------------------------------------------------------------------
// ppil_div
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. Flags quotients that do not fit QW bits.
// ----------------------------------------------------------------------------
module ppil_div #(
  parameter int unsigned LANES = 4,
  parameter int unsigned NW    = 83,
  parameter int unsigned DW    = 66,
  parameter int unsigned QW    = 32,
  parameter int unsigned SW    = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [SW-1:0]                side_i,
  input  logic [LANES-1:0][NW-1:0]     num_i,
  input  logic [DW-1:0]                den_i,
  output logic                         valid_o,
  output logic [SW-1:0]                side_o,
  output logic [LANES-1:0][QW-1:0]     quo_o,
  output logic [LANES-1:0]             ovf_o
);

  localparam int unsigned HW = NW - QW;

  logic [LANES-1:0][DW-1:0] rem_q  [QW+1];
  logic [LANES-1:0][QW-1:0] low_q  [QW+1];
  logic [LANES-1:0][QW-1:0] quo_q  [QW+1];
  logic [LANES-1:0]         ovf_q  [QW+1];
  logic [DW-1:0]            den_q  [QW+1];
  logic [SW-1:0]            side_q [QW+1];
  logic [QW:0]              vld_q;

  logic [LANES-1:0][DW:0]   trial [QW];
  logic [LANES-1:0]         take  [QW];
  logic [LANES-1:0][DW-1:0] nrem  [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      for (int l = 0; l < LANES; l++) begin
        trial[k][l] = {rem_q[k][l], low_q[k][l][QW-1]};
        take[k][l]  = trial[k][l] >= {1'b0, den_q[k]};
        nrem[k][l]  = take[k][l] ? DW'(trial[k][l] - {1'b0, den_q[k]}) : trial[k][l][DW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // entry: the high part must stay below the divisor for the quotient to fit
    for (int l = 0; l < LANES; l++) begin
      rem_q[0][l] <= DW'(num_i[l][NW-1:QW]);
      ovf_q[0][l] <= DW'(num_i[l][NW-1:NW-HW]) >= den_i;
      low_q[0][l] <= num_i[l][QW-1:0];
      quo_q[0][l] <= '0;
    end
    den_q[0]  <= den_i;
    side_q[0] <= side_i;
    for (int k = 1; k <= QW; k++) begin
      for (int l = 0; l < LANES; l++) begin
        rem_q[k][l] <= nrem[k-1][l];
        low_q[k][l] <= low_q[k-1][l] << 1;
        quo_q[k][l] <= {quo_q[k-1][l][QW-2:0], take[k-1][l]};
        ovf_q[k][l] <= ovf_q[k-1][l];
      end
      den_q[k]  <= den_q[k-1];
      side_q[k] <= side_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QW-1:0], valid_i};
    end
  end

  assign valid_o = vld_q[QW];
  assign side_o  = side_q[QW];
  assign quo_o   = quo_q[QW];
  assign ovf_o   = ovf_q[QW];

endmodule

/* rtl/plane_pair_intersection_line_top.sv */
// ----------------------------------------------------------------------------
// plane_pair_intersection_line_top
// Line of intersection of two planes in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// An item is taken whenever start_i is high; busy_o stays low, so one item can
// enter every cycle. Each item gives one result on res_o, marked by done_o for
// a single cycle. With 32-bit words the path has five stages for products, cross
// terms and divider setup, 33 for the slope and offset divider, four for
// saturation and the squared length, 32 for the square root, one for setup and
// 33 for the normalizing divider, and one output register. Results leave in
// the order items came in and must be
// taken when done_o is high.
module plane_pair_intersection_line_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  ppil_pkg::in_item_t    in_i,
  output logic                  busy_o,
  output logic                  done_o,
  output ppil_pkg::res_item_t   res_o
);

  localparam int unsigned W   = ppil_pkg::WordBits;
  localparam int unsigned PW  = 2 * W;
  localparam int unsigned CW  = 2 * W + 2;
  localparam int unsigned MW  = 2 * W + 1;
  localparam int unsigned NW1 = MW + FRAC_BITS + 2;
  localparam int unsigned DW1 = MW + 1;
  localparam int unsigned NW2 = W + FRAC_BITS + 2;
  localparam int unsigned DW2 = W + 1;
  localparam int unsigned RW  = W + 2;
  localparam int unsigned SW1 = $bits(ppil_pkg::ctl_t) + 4;
  localparam int unsigned SW2 = $bits(ppil_pkg::line_t);
  localparam logic [W-1:0] OneVal = (FRAC_BITS >= W - 1) ? {1'b0, {(W-1){1'b1}}}
                                                          : (W'(1) << FRAC_BITS);

  assign busy_o = 1'b0;

  // ---------------- stage a: products and reject test
  logic signed [PW-1:0] prod_d [12];
  logic signed [PW-1:0] a_prod_q [12];
  logic                 a_rej_q;
  logic                 a_norm_q;
  logic                 a_vld_q;
  logic                 rej_d;

  always_comb begin
    prod_d[0]  = PW'(in_i.p1_c) * PW'(in_i.p2_b);
    prod_d[1]  = PW'(in_i.p1_b) * PW'(in_i.p2_c);
    prod_d[2]  = PW'(in_i.p1_a) * PW'(in_i.p2_c);
    prod_d[3]  = PW'(in_i.p1_c) * PW'(in_i.p2_a);
    prod_d[4]  = PW'(in_i.p1_b) * PW'(in_i.p2_a);
    prod_d[5]  = PW'(in_i.p1_a) * PW'(in_i.p2_b);
    prod_d[6]  = PW'(in_i.p1_d) * PW'(in_i.p2_c);
    prod_d[7]  = PW'(in_i.p1_c) * PW'(in_i.p2_d);
    prod_d[8]  = PW'(in_i.p1_b) * PW'(in_i.p2_d);
    prod_d[9]  = PW'(in_i.p1_d) * PW'(in_i.p2_b);
    prod_d[10] = PW'(in_i.p1_d) * PW'(in_i.p2_a);
    prod_d[11] = PW'(in_i.p1_a) * PW'(in_i.p2_d);
    rej_d = ((in_i.p1_a == in_i.p2_a) && (in_i.p1_b == in_i.p2_b) &&
             (in_i.p1_c == in_i.p2_c) && (in_i.p1_d == in_i.p2_d)) ||
            ((in_i.p1_a == '0) && (in_i.p1_b == '0) && (in_i.p1_c == '0) &&
             (in_i.p1_d == '0)) ||
            ((in_i.p2_a == '0) && (in_i.p2_b == '0) && (in_i.p2_c == '0) &&
             (in_i.p2_d == '0));
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 12; i++) begin
      a_prod_q[i] <= prod_d[i];
    end
    a_rej_q  <= rej_d;
    a_norm_q <= in_i.normalize;
  end

  // ---------------- stage b: cross terms
  logic signed [CW-1:0] b_x_q, b_y_q, b_z_q, b_u_q, b_v_q, b_t_q;
  logic                 b_rej_q;
  logic                 b_norm_q;
  logic                 b_vld_q;

  always_ff @(posedge clk_i) begin
    b_x_q    <= CW'(a_prod_q[0])  - CW'(a_prod_q[1]);
    b_y_q    <= CW'(a_prod_q[2])  - CW'(a_prod_q[3]);
    b_z_q    <= CW'(a_prod_q[4])  - CW'(a_prod_q[5]);
    b_u_q    <= CW'(a_prod_q[6])  - CW'(a_prod_q[7]);
    b_v_q    <= CW'(a_prod_q[8])  - CW'(a_prod_q[9]);
    b_t_q    <= CW'(a_prod_q[10]) - CW'(a_prod_q[11]);
    b_rej_q  <= a_rej_q;
    b_norm_q <= a_norm_q;
  end

  // ---------------- stage c: axis choice, tried x, z, y
  logic signed [CW-1:0] c_den_q;
  logic signed [CW-1:0] c_num_q [4];
  ppil_pkg::ctl_t       c_ctl_q;
  logic                 c_vld_q;
  logic signed [CW-1:0] c_den_d;
  logic signed [CW-1:0] c_num_d [4];
  ppil_pkg::ctl_t       c_ctl_d;

  always_comb begin
    c_den_d        = b_x_q;
    c_num_d[0]     = b_y_q;
    c_num_d[1]     = b_u_q;
    c_num_d[2]     = b_z_q;
    c_num_d[3]     = b_v_q;
    c_ctl_d.status = ppil_pkg::StLine;
    c_ctl_d.axis   = ppil_pkg::AxisX;
    c_ctl_d.norm   = b_norm_q;
    if (b_rej_q) begin
      c_ctl_d.status = ppil_pkg::StReject;
    end else if (b_x_q != '0) begin
      c_ctl_d.axis = ppil_pkg::AxisX;
    end else if (b_z_q != '0) begin
      c_ctl_d.axis = ppil_pkg::AxisZ;
      c_den_d      = b_z_q;
      c_num_d[0]   = b_x_q;
      c_num_d[1]   = -b_v_q;
      c_num_d[2]   = b_y_q;
      c_num_d[3]   = -b_t_q;
    end else if (b_y_q != '0) begin
      c_ctl_d.axis = ppil_pkg::AxisY;
      c_den_d      = b_y_q;
      c_num_d[0]   = b_x_q;
      c_num_d[1]   = -b_u_q;
      c_num_d[2]   = b_z_q;
      c_num_d[3]   = b_t_q;
    end else begin
      c_ctl_d.status = ppil_pkg::StParallel;
    end
  end

  always_ff @(posedge clk_i) begin
    c_den_q <= c_den_d;
    for (int l = 0; l < 4; l++) begin
      c_num_q[l] <= c_num_d[l];
    end
    c_ctl_q <= c_ctl_d;
  end

  // ---------------- stage d: magnitudes and result signs
  logic [MW-1:0]        d_dmag_q;
  logic [MW-1:0]        d_nmag_q [4];
  logic [3:0]           d_neg_q;
  ppil_pkg::ctl_t       d_ctl_q;
  logic                 d_vld_q;

  always_ff @(posedge clk_i) begin
    d_dmag_q <= c_den_q[CW-1] ? MW'(-c_den_q) : MW'(c_den_q);
    for (int l = 0; l < 4; l++) begin
      d_nmag_q[l] <= c_num_q[l][CW-1] ? MW'(-c_num_q[l]) : MW'(c_num_q[l]);
      d_neg_q[l]  <= c_num_q[l][CW-1] ^ c_den_q[CW-1];
    end
    d_ctl_q <= c_ctl_q;
  end

  // ---------------- stage e: round to nearest as (2n + d) / 2d
  logic [3:0][NW1-1:0]  e_num_q;
  logic [DW1-1:0]       e_den_q;
  logic [3:0]           e_neg_q;
  ppil_pkg::ctl_t       e_ctl_q;
  logic                 e_vld_q;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 4; l++) begin
      e_num_q[l] <= (NW1'(d_nmag_q[l]) << (FRAC_BITS + 1)) + NW1'(d_dmag_q);
    end
    e_den_q <= {d_dmag_q, 1'b0};
    e_neg_q <= d_neg_q;
    e_ctl_q <= d_ctl_q;
  end

  // ---------------- slope and offset divider
  logic                 v1_vld;
  logic [SW1-1:0]       v1_side;
  logic [3:0][W-1:0]    v1_quo;
  logic [3:0]           v1_ovf;

  ppil_div #(
    .LANES (4),
    .NW    (NW1),
    .DW    (DW1),
    .QW    (W),
    .SW    (SW1)
  ) u_div_line (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (e_vld_q),
    .side_i  ({e_ctl_q, e_neg_q}),
    .num_i   (e_num_q),
    .den_i   (e_den_q),
    .valid_o (v1_vld),
    .side_o  (v1_side),
    .quo_o   (v1_quo),
    .ovf_o   (v1_ovf)
  );

  // ---------------- stage f: saturate slopes and offsets
  logic [3:0][W-1:0]    f_lin_q;
  ppil_pkg::ctl_t       f_ctl_q;
  logic                 f_vld_q;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 4; l++) begin
      f_lin_q[l] <= ppil_pkg::sat_round(v1_quo[l], v1_ovf[l], v1_side[l]);
    end
    f_ctl_q <= ppil_pkg::ctl_t'(v1_side[SW1-1:4]);
  end

  // ---------------- stage g: direction vector
  ppil_pkg::line_t      g_line_d;
  ppil_pkg::line_t      g_line_q;
  logic                 g_vld_q;

  always_comb begin
    g_line_d.ctl = f_ctl_q;
    g_line_d.lin = f_lin_q;
    case (f_ctl_q.axis)
      ppil_pkg::AxisX: g_line_d.dir = {f_lin_q[2], f_lin_q[0], OneVal};
      ppil_pkg::AxisY: g_line_d.dir = {f_lin_q[2], OneVal, f_lin_q[0]};
      ppil_pkg::AxisZ: g_line_d.dir = {OneVal, f_lin_q[2], f_lin_q[0]};
      default:         g_line_d.dir = '0;
    endcase
    for (int k = 0; k < 3; k++) begin
      g_line_d.mag[k] = ppil_pkg::mag_w(g_line_d.dir[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    g_line_q <= g_line_d;
  end

  // ---------------- stage h: squares
  logic [PW-1:0]        h_sq_q [3];
  ppil_pkg::line_t      h_line_q;
  logic                 h_vld_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      h_sq_q[k] <= PW'(g_line_q.mag[k]) * PW'(g_line_q.mag[k]);
    end
    h_line_q <= g_line_q;
  end

  // ---------------- square root, one root bit per stage; index 0 holds the sum
  logic [PW-1:0]        sq_src_q  [W+1];
  logic [RW-1:0]        sq_rem_q  [W+1];
  logic [W-1:0]         sq_root_q [W+1];
  ppil_pkg::line_t      sq_line_q [W+1];
  logic [W:0]           sq_vld_q;
  logic [RW+1:0]        sq_cand [W];
  logic [RW+1:0]        sq_trial [W];
  logic                 sq_take [W];
  logic [RW-1:0]        sq_nrem [W];

  always_comb begin
    for (int k = 0; k < W; k++) begin
      sq_cand[k]  = {sq_rem_q[k], sq_src_q[k][PW-1:PW-2]};
      sq_trial[k] = (RW+2)'({sq_root_q[k], 2'b01});
      sq_take[k]  = sq_cand[k] >= sq_trial[k];
      sq_nrem[k]  = sq_take[k] ? RW'(sq_cand[k] - sq_trial[k]) : RW'(sq_cand[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    sq_src_q[0]  <= h_sq_q[0] + h_sq_q[1] + h_sq_q[2];
    sq_rem_q[0]  <= '0;
    sq_root_q[0] <= '0;
    sq_line_q[0] <= h_line_q;
    for (int k = 1; k <= W; k++) begin
      sq_src_q[k]  <= sq_src_q[k-1] << 2;
      sq_rem_q[k]  <= sq_nrem[k-1];
      sq_root_q[k] <= {sq_root_q[k-1][W-2:0], sq_take[k-1]};
      sq_line_q[k] <= sq_line_q[k-1];
    end
  end

  // ---------------- stage j: setup for unit scaling
  logic [2:0][NW2-1:0]  j_num_q;
  logic [DW2-1:0]       j_den_q;
  ppil_pkg::line_t      j_line_q;
  logic                 j_vld_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      j_num_q[k] <= (NW2'(sq_line_q[W].mag[k]) << (FRAC_BITS + 1)) + NW2'(sq_root_q[W]);
    end
    j_den_q  <= {sq_root_q[W], 1'b0};
    j_line_q <= sq_line_q[W];
  end

  // ---------------- normalizing divider
  logic                 v2_vld;
  logic [SW2-1:0]       v2_side;
  logic [2:0][W-1:0]    v2_quo;
  logic [2:0]           v2_ovf;
  ppil_pkg::line_t      v2_line;

  ppil_div #(
    .LANES (3),
    .NW    (NW2),
    .DW    (DW2),
    .QW    (W),
    .SW    (SW2)
  ) u_div_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (j_vld_q),
    .side_i  (j_line_q),
    .num_i   (j_num_q),
    .den_i   (j_den_q),
    .valid_o (v2_vld),
    .side_o  (v2_side),
    .quo_o   (v2_quo),
    .ovf_o   (v2_ovf)
  );

  assign v2_line = ppil_pkg::line_t'(v2_side);

  // ---------------- stage k: output register
  logic [W-1:0]         k_dir_d [3];
  ppil_pkg::res_item_t  res_d;
  ppil_pkg::res_item_t  res_q;
  logic                 done_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      k_dir_d[k] = v2_line.ctl.norm ?
                   ppil_pkg::sat_round(v2_quo[k], v2_ovf[k], v2_line.dir[k][W-1]) :
                   v2_line.dir[k];
    end
    res_d            = '0;
    res_d.status     = v2_line.ctl.status;
    res_d.param_axis = ppil_pkg::AxisX;
    if (v2_line.ctl.status == ppil_pkg::StLine) begin
      res_d.param_axis    = v2_line.ctl.axis;
      res_d.slope_first   = v2_line.lin[0];
      res_d.offset_first  = v2_line.lin[1];
      res_d.slope_second  = v2_line.lin[2];
      res_d.offset_second = v2_line.lin[3];
      res_d.dir_x         = k_dir_d[0];
      res_d.dir_y         = k_dir_d[1];
      res_d.dir_z         = k_dir_d[2];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // valid bits that travel with each item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
      c_vld_q  <= 1'b0;
      d_vld_q  <= 1'b0;
      e_vld_q  <= 1'b0;
      f_vld_q  <= 1'b0;
      g_vld_q  <= 1'b0;
      h_vld_q  <= 1'b0;
      sq_vld_q <= '0;
      j_vld_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      a_vld_q  <= start_i;
      b_vld_q  <= a_vld_q;
      c_vld_q  <= b_vld_q;
      d_vld_q  <= c_vld_q;
      e_vld_q  <= d_vld_q;
      f_vld_q  <= v1_vld;
      g_vld_q  <= f_vld_q;
      h_vld_q  <= g_vld_q;
      sq_vld_q <= {sq_vld_q[W-1:0], h_vld_q};
      j_vld_q  <= sq_vld_q[W];
      done_q   <= v2_vld;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
